// File: sv/slws_pkg.sv
// ----------------------------------------------------------------------------
// slws_pkg
// shared types, constants and helpers for the sliding window lane search
// ----------------------------------------------------------------------------
package slws_pkg;

   // default image geometry
   localparam int IMG_WIDTH_DEF  = 640;
   localparam int IMG_HEIGHT_DEF = 480;

   // maximum windows per search
   localparam int MAX_WINDOWS = 60;
   localparam int NWIN_W      = $clog2(MAX_WINDOWS);

   // register reset values
   localparam logic [8:0] START_ROW_RST  = 9'd420;
   localparam logic [9:0] WIN_WIDTH_RST  = 10'd120;
   localparam logic [8:0] WIN_HEIGHT_RST = 9'd60;

   // register file
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_START_ROW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_HEIGHT = 2'd2;

   // request modes
   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_SEARCH = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WIN,
      ST_ROW0,
      ST_SCAN,
      ST_DRAIN,
      ST_PREP,
      ST_DIV,
      ST_PX,
      ST_POST
   } state_type;

   function automatic int imax(int a, int b);
      return (a > b) ? a : b;
   endfunction

endpackage

// File: sv/slws_ram.sv
// ----------------------------------------------------------------------------
// slws_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module slws_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = slws_pkg::IMG_WIDTH_DEF * slws_pkg::IMG_HEIGHT_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/sliding_window_lane_search.sv
// ----------------------------------------------------------------------------
// sliding_window_lane_search
// binary image store with a sliding window lane search over it
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  req     | in        | req_valid/req_stall  | mode, pixel_row/col/value, start_x
//  rsp     | out       | rsp_valid/rsp_stall  | point_x, point_y, found, last
//  csr     | in        | csr_we               | csr_index, csr_wdata
//
//  load requests are taken one per cycle; a search request holds req_stall high
//  until its last window is written to the output register
//  per window: a scan of each pixel of the window clipped to the image, then a
//  division of the column sum when it holds set pixels; a window wholly outside
//  the image is not scanned; a waiting result holds the search before its next window
//  reset is synchronous and clears control only; the image ram is not cleared
//
module sliding_window_lane_search #(
   parameter int IMG_WIDTH  = slws_pkg::IMG_WIDTH_DEF,
   parameter int IMG_HEIGHT = slws_pkg::IMG_HEIGHT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_mode,
   input  logic [8:0]                        req_pixel_row,
   input  logic [9:0]                        req_pixel_col,
   input  logic [7:0]                        req_pixel_value,
   input  logic [9:0]                        req_start_x,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [9:0]                        rsp_point_x,
   output logic [8:0]                        rsp_point_y,
   output logic                              rsp_found,
   output logic                              rsp_last,
   // register writes
   input  logic                              csr_we,
   input  logic [slws_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [slws_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // geometry derived widths
   localparam int DEPTH  = IMG_WIDTH * IMG_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int COL_W  = $clog2(IMG_WIDTH);
   localparam int ROW_W  = $clog2(IMG_HEIGHT);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = CNT_W + COL_W;
   localparam int STEP_W = $clog2(COL_W);
   localparam int LW     = slws_pkg::imax(COL_W, 10);  // window left column
   localparam int XW     = LW + 3;                     // signed column math
   localparam int YW     = slws_pkg::imax(ROW_W, 9) + 2;
   localparam int NW     = slws_pkg::NWIN_W;

   // configuration registers
   logic [8:0] start_row_ff, start_row_in;
   logic [9:0] win_width_ff, win_width_in;
   logic [8:0] win_height_ff, win_height_in;

   // control
   slws_pkg::state_type state_ff, state_in;
   logic [LW-1:0]       left_ff, left_in;
   logic [8:0]          top_ff, top_in;
   logic [NW-1:0]       nwin_ff, nwin_in;

   // window scan
   logic [ADDR_W-1:0]   base_ff, base_in;
   logic [COL_W-1:0]    c_last_ff, c_last_in;
   logic [ROW_W-1:0]    r_last_ff, r_last_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [ADDR_W-1:0]   rowstart_ff, rowstart_in;
   logic                rd_pend_ff, rd_pend_in;
   logic [COL_W-1:0]    rd_col_ff, rd_col_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   // divider
   logic [SUM_W-1:0]    rem_ff, rem_in;
   logic [SUM_W-1:0]    dvs_ff, dvs_in;
   logic [COL_W-1:0]    quo_ff, quo_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [XW-1:0]       px_ff, px_in;

   // pixel write pipe
   logic                wr_en_ff, wr_en_in;
   logic [ADDR_W-1:0]   wr_addr_ff, wr_addr_in;
   logic                wr_data_ff, wr_data_in;
   logic                ram_rdata;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [9:0]          rsp_point_x_ff, rsp_point_x_in;
   logic [8:0]          rsp_point_y_ff, rsp_point_y_in;
   logic                rsp_found_ff, rsp_found_in;
   logic                rsp_last_ff, rsp_last_in;

   // handshake and window decode
   logic                req_fire;
   logic                out_free;
   logic                post_go;
   logic [XW-1:0]       c_end, c_lim;
   logic [YW-1:0]       r_end, r_lim;
   logic                win_empty;
   logic                row_end;
   logic                scan_end;
   logic                div_done;
   logic                win_last;
   logic [8:0]          top_next;
   logic signed [XW-1:0] nx_raw, nx_lo, nx_hi, nx_fin;

   slws_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_image_ram (
      .clock   (clock),
      .wr_en   (wr_en_ff),
      .wr_addr (wr_addr_ff),
      .wr_data (wr_data_ff),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   // window bounds clipped to the image
   always_comb begin
      c_end     = XW'(left_ff) + XW'(win_width_ff);
      c_lim     = (c_end > XW'(IMG_WIDTH)) ? XW'(IMG_WIDTH) : c_end;
      r_end     = YW'(top_ff) + YW'(win_height_ff);
      r_lim     = (r_end > YW'(IMG_HEIGHT)) ? YW'(IMG_HEIGHT) : r_end;
      win_empty = (XW'(left_ff) >= c_lim) || (YW'(top_ff) >= r_lim);
      row_end   = (col_ff == c_last_ff);
      scan_end  = row_end && (row_ff == r_last_ff);
      div_done  = (step_ff == STEP_W'(COL_W - 1));
      // final window when the next top passes row zero or the cap is hit
      win_last  = ({1'b0, win_height_ff} > {1'b0, top_ff}) ||
                  (nwin_ff == NW'(slws_pkg::MAX_WINDOWS - 1));
      top_next  = win_last && (win_height_ff > top_ff) ? 9'd0 : top_ff - win_height_ff;
   end

   // next left column: mean minus half width, clamped into the image
   always_comb begin
      nx_raw = $signed(px_ff) - $signed(XW'(win_width_ff[9:1]) + XW'(win_width_ff[0]));
      nx_lo  = (nx_raw < 0) ? '0 : nx_raw;
      nx_hi  = nx_lo;
      if ((nx_lo + $signed(XW'(win_width_ff))) >= $signed(XW'(IMG_WIDTH))) begin
         nx_hi = $signed(XW'(IMG_WIDTH)) - $signed(XW'(win_width_ff)) - $signed(XW'(1));
      end
      nx_fin = (nx_hi < 0) ? '0 : nx_hi;
   end

   // state machine: next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         slws_pkg::ST_IDLE: begin
            if (req_fire && (req_mode == slws_pkg::MODE_SEARCH)) begin
               state_in = slws_pkg::ST_WIN;
            end
         end
         slws_pkg::ST_WIN: begin
            state_in = win_empty ? slws_pkg::ST_PREP : slws_pkg::ST_ROW0;
         end
         slws_pkg::ST_ROW0: begin
            state_in = slws_pkg::ST_SCAN;
         end
         slws_pkg::ST_SCAN: begin
            if (scan_end) begin
               state_in = slws_pkg::ST_DRAIN;
            end
         end
         slws_pkg::ST_DRAIN: begin
            state_in = slws_pkg::ST_PREP;
         end
         slws_pkg::ST_PREP: begin
            state_in = (cnt_ff != '0) ? slws_pkg::ST_DIV : slws_pkg::ST_PX;
         end
         slws_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = slws_pkg::ST_PX;
            end
         end
         slws_pkg::ST_PX: begin
            state_in = slws_pkg::ST_POST;
         end
         slws_pkg::ST_POST: begin
            if (out_free) begin
               state_in = win_last ? slws_pkg::ST_IDLE : slws_pkg::ST_WIN;
            end
         end
         default: begin
            state_in = slws_pkg::ST_IDLE;
         end
      endcase
   end

   // state machine: outputs
   always_comb begin
      req_stall  = 1'b1;
      rd_pend_in = 1'b0;
      post_go    = 1'b0;
      case (state_ff)
         slws_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         slws_pkg::ST_SCAN: begin
            rd_pend_in = 1'b1;
         end
         slws_pkg::ST_POST: begin
            post_go = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign req_fire = req_valid && !req_stall;
   // output slot is free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // datapath
   always_comb begin
      start_row_in   = start_row_ff;
      win_width_in   = win_width_ff;
      win_height_in  = win_height_ff;
      left_in        = left_ff;
      top_in         = top_ff;
      nwin_in        = nwin_ff;
      base_in        = base_ff;
      c_last_in      = c_last_ff;
      r_last_in      = r_last_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      addr_in        = addr_ff;
      rowstart_in    = rowstart_ff;
      rd_col_in      = col_ff;
      sum_in         = sum_ff;
      cnt_in         = cnt_ff;
      rem_in         = rem_ff;
      dvs_in         = dvs_ff;
      quo_in         = quo_ff;
      step_in        = step_ff;
      px_in          = px_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_point_x_in = rsp_point_x_ff;
      rsp_point_y_in = rsp_point_y_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_last_in    = rsp_last_ff;

      // register writes
      if (csr_we) begin
         case (csr_index)
            slws_pkg::CSR_START_ROW:  start_row_in  = csr_wdata[8:0];
            slws_pkg::CSR_WIN_WIDTH:  win_width_in  = csr_wdata[9:0];
            slws_pkg::CSR_WIN_HEIGHT: win_height_in = csr_wdata[8:0];
            default: begin
               start_row_in = start_row_ff;
            end
         endcase
      end

      // pixel load, registered in the write pipe before the ram write
      wr_en_in   = req_fire && (req_mode == slws_pkg::MODE_LOAD) &&
                   (32'(req_pixel_row) < 32'(IMG_HEIGHT)) &&
                   (32'(req_pixel_col) < 32'(IMG_WIDTH));
      wr_addr_in = ADDR_W'(req_pixel_row) * ADDR_W'(IMG_WIDTH) + ADDR_W'(req_pixel_col);
      wr_data_in = (req_pixel_value != 8'd0);

      // set pixels returned by the ram
      if (rd_pend_ff && ram_rdata) begin
         sum_in = sum_ff + SUM_W'(rd_col_ff);
         cnt_in = cnt_ff + CNT_W'(1);
      end

      case (state_ff)
         slws_pkg::ST_IDLE: begin
            if (req_fire && (req_mode == slws_pkg::MODE_SEARCH)) begin
               left_in = LW'(req_start_x);
               top_in  = start_row_ff;
               nwin_in = '0;
            end
         end
         slws_pkg::ST_WIN: begin
            c_last_in = COL_W'(c_lim - XW'(1));
            r_last_in = ROW_W'(r_lim - YW'(1));
            base_in   = ADDR_W'(top_ff) * ADDR_W'(IMG_WIDTH);
            sum_in    = '0;
            cnt_in    = '0;
         end
         slws_pkg::ST_ROW0: begin
            row_in      = ROW_W'(top_ff);
            col_in      = COL_W'(left_ff);
            rowstart_in = base_ff + ADDR_W'(left_ff);
            addr_in     = base_ff + ADDR_W'(left_ff);
         end
         slws_pkg::ST_SCAN: begin
            if (row_end) begin
               if (!scan_end) begin
                  row_in      = row_ff + ROW_W'(1);
                  col_in      = COL_W'(left_ff);
                  rowstart_in = rowstart_ff + ADDR_W'(IMG_WIDTH);
                  addr_in     = rowstart_ff + ADDR_W'(IMG_WIDTH);
               end
            end else begin
               col_in  = col_ff + COL_W'(1);
               addr_in = addr_ff + ADDR_W'(1);
            end
         end
         slws_pkg::ST_PREP: begin
            rem_in  = sum_ff;
            dvs_in  = SUM_W'(cnt_ff) << (COL_W - 1);
            quo_in  = '0;
            step_in = '0;
         end
         slws_pkg::ST_DIV: begin
            // restoring division, one quotient bit per cycle
            if (rem_ff >= dvs_ff) begin
               rem_in = rem_ff - dvs_ff;
               quo_in = {quo_ff[COL_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_ff[COL_W-2:0], 1'b0};
            end
            dvs_in  = dvs_ff >> 1;
            step_in = step_ff + STEP_W'(1);
         end
         slws_pkg::ST_PX: begin
            // empty window reports its centre column
            px_in = (cnt_ff != '0) ? XW'(quo_ff)
                                   : XW'(left_ff) + XW'(win_width_ff[9:1]);
         end
         slws_pkg::ST_POST: begin
            if (post_go) begin
               rsp_valid_in   = 1'b1;
               rsp_point_x_in = px_ff[9:0];
               rsp_point_y_in = top_ff + {1'b0, win_height_ff[8:1]};
               rsp_found_in   = (cnt_ff != '0);
               rsp_last_in    = win_last;
               left_in        = LW'(nx_fin);
               top_in         = top_next;
               nwin_in        = nwin_ff + NW'(1);
            end
         end
         default: begin
            px_in = px_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= slws_pkg::ST_IDLE;
         start_row_ff  <= slws_pkg::START_ROW_RST;
         win_width_ff  <= slws_pkg::WIN_WIDTH_RST;
         win_height_ff <= slws_pkg::WIN_HEIGHT_RST;
         left_ff       <= '0;
         top_ff        <= '0;
         nwin_ff       <= '0;
         rd_pend_ff    <= 1'b0;
         wr_en_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         start_row_ff  <= start_row_in;
         win_width_ff  <= win_width_in;
         win_height_ff <= win_height_in;
         left_ff       <= left_in;
         top_ff        <= top_in;
         nwin_ff       <= nwin_in;
         rd_pend_ff    <= rd_pend_in;
         wr_en_ff      <= wr_en_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      base_ff        <= base_in;
      c_last_ff      <= c_last_in;
      r_last_ff      <= r_last_in;
      row_ff         <= row_in;
      col_ff         <= col_in;
      addr_ff        <= addr_in;
      rowstart_ff    <= rowstart_in;
      rd_col_ff      <= rd_col_in;
      sum_ff         <= sum_in;
      cnt_ff         <= cnt_in;
      rem_ff         <= rem_in;
      dvs_ff         <= dvs_in;
      quo_ff         <= quo_in;
      step_ff        <= step_in;
      px_ff          <= px_in;
      wr_addr_ff     <= wr_addr_in;
      wr_data_ff     <= wr_data_in;
      rsp_point_x_ff <= rsp_point_x_in;
      rsp_point_y_ff <= rsp_point_y_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_point_x = rsp_point_x_ff;
   assign rsp_point_y = rsp_point_y_ff;
   assign rsp_found   = rsp_found_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

// File: sv/slws_checker.sv
// ----------------------------------------------------------------------------
// slws_checker
// port level checks for the sliding window lane search
// ----------------------------------------------------------------------------
module slws_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_mode,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [9:0] rsp_point_x,
   input logic [8:0] rsp_point_y,
   input logic       rsp_found,
   input logic       rsp_last
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_point_x) &&
      $stable(rsp_point_y) && $stable(rsp_found) && $stable(rsp_last))
      else $error("stalled result changed");

   // no request taken while a search still has windows to report
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("request taken in the middle of a search");

   // a search request closes the request side
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_mode |=> req_stall)
      else $error("request side open right after a search request");

   // a load request makes no result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_mode && !rsp_valid |=> !rsp_valid)
      else $error("result after a load request");

endmodule

bind sliding_window_lane_search slws_checker u_slws_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_mode    (req_mode),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_point_x (rsp_point_x),
   .rsp_point_y (rsp_point_y),
   .rsp_found   (rsp_found),
   .rsp_last    (rsp_last)
);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the sliding window lane search: a whole lane frame
// is loaded pixel by pixel, then directed and random searches run under
// several window settings, and every window point is checked in order
// against a bit-exact software search over a copy of the frame
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IMG_W         = slws_pkg::IMG_WIDTH_DEF;
   localparam int IMG_H         = slws_pkg::IMG_HEIGHT_DEF;
   localparam int HALF_PERIOD   = 10;
   localparam int SETTLE_CYCLES = 50;       // covers a trailing pixel write
   localparam int HOLD_CYCLES   = 3000;     // long result back-pressure
   localparam int BLOCK_ITEMS   = 45;       // minimum random requests per setting
   localparam int RAND_BLOCKS   = 9;
   localparam int CYCLE_LIMIT   = 20000000;
   localparam int REPORT_MAX    = 10;

   // one request as offered on the input channel
   typedef struct packed {
      logic       mode;
      logic [8:0] row;
      logic [9:0] col;
      logic [7:0] value;
      logic [9:0] start_x;
   } lane_req_type;

   // one window point as returned on the result channel
   typedef struct packed {
      logic [9:0] x;
      logic [8:0] y;
      logic       found;
      logic       last;
   } lane_point_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #(HALF_PERIOD) clock = ~clock;

   // block ports
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   lane_req_type                    req_now   = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [9:0]                      rsp_point_x;
   logic [8:0]                      rsp_point_y;
   logic                            rsp_found;
   logic                            rsp_last;
   logic                            csr_we    = 1'b0;
   logic [slws_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [slws_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   sliding_window_lane_search u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_now.mode),
      .req_pixel_row   (req_now.row),
      .req_pixel_col   (req_now.col),
      .req_pixel_value (req_now.value),
      .req_start_x     (req_now.start_x),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_found       (rsp_found),
      .rsp_last        (rsp_last),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // requests waiting to be offered, and points still owed by the block
   lane_req_type   req_backlog[$];
   lane_point_type lane_points_due[$];

   // shadow of the image and of the window registers
   bit         frame_bits [IMG_W*IMG_H];
   logic [8:0] start_row_q  = slws_pkg::START_ROW_RST;
   logic [9:0] win_width_q  = slws_pkg::WIN_WIDTH_RST;
   logic [8:0] win_height_q = slws_pkg::WIN_HEIGHT_RST;

   // idling and back-pressure controls, set by the stimulus process
   int send_idle_pct = 20;
   int recv_idle_pct = 66;
   bit hold_armed    = 1'b0;
   int hold_left     = 0;

   // bookkeeping
   bit req_taken       = 1'b0;
   int cycle_count     = 0;
   int mismatch_count  = 0;
   int loads_taken     = 0;
   int searches_taken  = 0;
   int points_checked  = 0;
   int points_found    = 0;

   // walk the windows of one search over the shadow frame and queue
   // the point that each window must give
   function automatic void trace_lane(input logic [9:0] first_left);
      int             wd, ht, left, top, r, c, r_end, c_end, px, nx, count, n;
      longint         col_sum;
      bit             final_win;
      lane_point_type pt;
      wd        = win_width_q;
      ht        = win_height_q;
      left      = first_left;
      top       = start_row_q;
      n         = 0;
      final_win = 1'b0;
      while (!final_win) begin
         col_sum = 0;
         count   = 0;
         // only the part of the window inside the image is scanned
         r_end = (top + ht > IMG_H) ? IMG_H : top + ht;
         c_end = (left + wd > IMG_W) ? IMG_W : left + wd;
         for (r = top; r < r_end; r++)
            for (c = left; c < c_end; c++)
               if (frame_bits[r*IMG_W + c]) begin
                  col_sum += c;
                  count++;
               end
         // mean column of set pixels, or the window centre when empty
         px = (count != 0) ? int'(col_sum / count) : left + wd / 2;
         n++;
         // stop when the next top passes row 0, or at the window cap
         final_win = (top - ht < 0) || (n >= slws_pkg::MAX_WINDOWS);
         pt.x     = px[9:0];
         pt.y     = 9'(top + ht / 2);
         pt.found = (count != 0);
         pt.last  = final_win;
         lane_points_due.insert(lane_points_due.size(), pt);
         // recentre on the point, clamped to both image edges
         nx = px - (wd + 1) / 2;
         if (nx < 0) nx = 0;
         if (nx + wd >= IMG_W) nx = IMG_W - wd - 1;
         if (nx < 0) nx = 0;
         left = nx;
         top  = (top - ht < 0) ? 0 : top - ht;
      end
   endfunction

   // driver: next request at the falling edge, held while stalled
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            req_now   <= req_backlog.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result back-pressure: random idling plus the long hold-off
   always @(negedge clock) begin
      rsp_stall <= (hold_left != 0) || ($urandom_range(99, 0) < recv_idle_pct);
   end

   // long hold-off, counted here once the stimulus arms it
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_armed) begin
         hold_left <= HOLD_CYCLES;
      end
   end

   // monitor: update the shadow on each accepted request, check each point
   always @(posedge clock) begin
      lane_point_type got, want;
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken) begin
         if (req_now.mode == slws_pkg::MODE_LOAD) begin
            loads_taken++;
            // loads outside the image are dropped
            if (req_now.row < IMG_H && req_now.col < IMG_W)
               frame_bits[req_now.row*IMG_W + req_now.col] = (req_now.value != 0);
         end else begin
            searches_taken++;
            trace_lane(req_now.start_x);
         end
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_point_x, rsp_point_y, rsp_found, rsp_last};
         if (lane_points_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("cycle %0d: unexpected point x=%0d y=%0d found=%0b last=%0b",
                        cycle_count, got.x, got.y, got.found, got.last);
         end else begin
            want = lane_points_due.pop_front();
            points_checked++;
            if (want.found) points_found++;
            if (got.x !== want.x || got.y !== want.y ||
                got.found !== want.found || got.last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("cycle %0d: point mismatch, expected x=%0d y=%0d found=%0b",
                           cycle_count, want.x, want.y, want.found,
                           " last=%0b, got x=%0d y=%0d found=%0b last=%0b",
                           want.last, got.x, got.y, got.found, got.last);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d points still due",
                  cycle_count, lane_points_due.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // wait until every request is in and every point is out, then let
   // a trailing pixel write finish
   task automatic settle();
      while (req_backlog.size() != 0 || req_valid || lane_points_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // rewrite all window registers once the block is quiet
   task automatic reprogram(input int sr, input int wd, input int ht);
      settle();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= slws_pkg::CSR_START_ROW;
      csr_wdata <= slws_pkg::CSR_DATA_W'(sr);
      @(negedge clock);
      csr_index <= slws_pkg::CSR_WIN_WIDTH;
      csr_wdata <= slws_pkg::CSR_DATA_W'(wd);
      @(negedge clock);
      csr_index <= slws_pkg::CSR_WIN_HEIGHT;
      csr_wdata <= slws_pkg::CSR_DATA_W'(ht);
      @(negedge clock);
      csr_we    <= 1'b0;
      start_row_q  = 9'(sr);
      win_width_q  = 10'(wd);
      win_height_q = 9'(ht);
   endtask

   // pixel write request; the start column is a don't-care here
   task automatic queue_load(input int r, input int c, input int v);
      lane_req_type it;
      it.mode    = slws_pkg::MODE_LOAD;
      it.row     = 9'(r);
      it.col     = 10'(c);
      it.value   = 8'(v);
      it.start_x = 10'($urandom_range(IMG_W - 1, 0));
      req_backlog.insert(req_backlog.size(), it);
   endtask

   // search request; pixel fields are don't-cares here
   task automatic queue_search(input int sx);
      lane_req_type it;
      it.mode    = slws_pkg::MODE_SEARCH;
      it.row     = 9'($urandom_range(IMG_H - 1, 0));
      it.col     = 10'($urandom_range(IMG_W - 1, 0));
      it.value   = 8'($urandom_range(255, 0));
      it.start_x = 10'(sx);
      req_backlog.insert(req_backlog.size(), it);
   endtask

   // stimulus
   initial begin
      int  r, c, blk, pushed, nloads, i, left_lane, right_lane, sr, wd, ht, rr, cc, vv;
      bit  lit;

      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      @(posedge clock);

      // whole frame first: a curved solid lane, a dashed lane and sparse
      // noise in the middle columns; the outer columns stay clean so that
      // empty windows can be placed there
      for (r = 0; r < IMG_H; r++) begin
         left_lane  = 150 + (r * r) / 2000;
         right_lane = 470 - r / 8;
         for (c = 0; c < IMG_W; c++) begin
            lit = (c >= left_lane - 3 && c <= left_lane + 3) ||
                  (((r / 40) % 2 == 0) && c >= right_lane - 4 && c <= right_lane + 4) ||
                  (c >= 100 && c < 560 && $urandom_range(99, 0) == 0);
            queue_load(r, c, lit ? $urandom_range(255, 1) : 0);
         end
      end
      // search with the register reset values
      queue_search(100);

      // directed: bottom row clipped, sixty windows of 8 by 8 pixels
      reprogram(479, 8, 8);
      queue_search(0);
      queue_search(639);
      // window cap reached while still above row 0
      reprogram(479, 16, 5);
      queue_search(160);
      // zero height never climbs
      reprogram(300, 16, 0);
      queue_search(620);
      // tallest window clipped to one row, centre row wraps
      reprogram(479, 8, 480);
      queue_search(632);
      // window wider than the image: left column saturates at 0
      reprogram(20, 1000, 8);
      queue_search(5);
      // widest legal window in one go
      reprogram(0, 639, 8);
      queue_search(0);
      // empty windows at both edges, right edge clamp
      reprogram(60, 16, 20);
      queue_search(0);
      queue_search(630);
      queue_search(600);
      // loads outside the image are dropped, then a few lane pixels
      // appear in the clean area and one lane pixel is cleared
      queue_load(480, 10, 255);
      queue_load(511, 1023, 128);
      queue_load(5, 640, 1);
      queue_load(5, 1023, 7);
      queue_load(50, 610, 255);
      queue_load(55, 612, 1);
      queue_load(45, 608, 128);
      queue_load(30, 150, 0);
      queue_search(600);
      queue_search(145);

      // random: short bursts of pixel writes followed by a search, under
      // a fresh window setting per block
      for (blk = 0; blk < RAND_BLOCKS; blk++) begin
         if (blk == 4) begin
            // a few wide but shallow searches
            sr = $urandom_range(16, 0);
            wd = $urandom_range(639, 100);
            ht = $urandom_range(12, 8);
         end else begin
            sr = $urandom_range(479, 0);
            wd = $urandom_range(28, 8);
            ht = ($urandom_range(3, 0) == 0) ? $urandom_range(480, 120)
                                              : $urandom_range(120, 8);
         end
         reprogram(sr, wd, ht);

         // receiver idles more first, then the sender, then neither
         case (blk / 3)
            0: begin
               send_idle_pct = 20;
               recv_idle_pct = 66;
            end
            1: begin
               send_idle_pct = 66;
               recv_idle_pct = 20;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase

         pushed = 0;
         while (pushed < BLOCK_ITEMS) begin
            nloads = $urandom_range(5, 0);
            for (i = 0; i < nloads; i++) begin
               rr = ($urandom_range(9, 0) == 0) ? $urandom_range(511, IMG_H)
                                                : $urandom_range(IMG_H - 1, 0);
               cc = ($urandom_range(9, 0) == 0) ? $urandom_range(1023, IMG_W)
                                                : $urandom_range(IMG_W - 1, 0);
               vv = $urandom_range(1, 0) ? $urandom_range(255, 1) : 0;
               queue_load(rr, cc, vv);
            end
            queue_search($urandom_range(IMG_W - 1, 0));
            pushed += nloads + 1;
         end

         // results held off for a long stretch while requests keep coming
         if (blk == 6) begin
            hold_armed = 1'b1;
            @(posedge clock);
            while (hold_left == 0) @(posedge clock);
            hold_armed = 1'b0;
         end
      end

      settle();
      if (lane_points_due.size() != 0) mismatch_count += lane_points_due.size();

      $display("covered %0d pixel writes and %0d searches over %0d register settings",
               loads_taken, searches_taken, RAND_BLOCKS + 8);
      $display("checked %0d window points, %0d of them on lane pixels, %0d mismatches",
               points_checked, points_found, mismatch_count);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: sliding_window_lane_search.f
sv/slws_pkg.sv
sv/slws_ram.sv
sv/sliding_window_lane_search.sv
sv/slws_checker.sv
tb/testbench.sv
